// ===== design/pag_branch_predictor_defines.svh =====
// Assertion macros for the branch predictor checker.
`ifndef PAG_BRANCH_PREDICTOR_DEFINES_SVH
`define PAG_BRANCH_PREDICTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PAG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PAG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pag_pkg.sv =====
// Shared constants, types and the index fold of the branch predictor.
package pag_pkg;

    localparam int HIST_ENTRIES = 1024;
    localparam int HIST_LEN     = 10;
    localparam int PAT_ENTRIES  = 1 << HIST_LEN;
    localparam int IDX_W        = $clog2(HIST_ENTRIES);
    localparam int CLR_LEN      = (HIST_ENTRIES > PAT_ENTRIES) ? HIST_ENTRIES : PAT_ENTRIES;
    localparam int CLR_W        = $clog2(CLR_LEN);

    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(HIST_ENTRIES - 1);

    localparam logic [1:0] REQ_PREDICT = 2'd0;
    localparam logic [1:0] REQ_UPDATE  = 2'd1;
    localparam logic [1:0] REQ_TRAIN   = 2'd2;

    typedef logic [HIST_LEN-1:0] hist_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] req;
        logic       taken;
        hist_t      hist;
    } pht_req_t;

    typedef struct packed {
        logic             en;
        logic [CLR_W-1:0] addr;
    } clr_t;

    function automatic logic [IDX_W-1:0] fold_index(input logic [63:0] pc);
        logic [63:0] v;
        v = pc >> 2;
        v = v ^ (v >> 10);
        v = v ^ (v >> 20);
        v = v ^ (v >> 30);
        return v[IDX_W-1:0] & IDX_MASK;
    endfunction

endpackage

// ===== design/pag_pht.sv =====
// Pattern history table stage with counter training and the result register.
module pag_pht
    import pag_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  clr_t     clr,
    input  pht_req_t req,
    output logic     advance,
    input  logic     out_stall,
    output logic     out_valid,
    output logic     pred_taken,
    output hist_t    history_used
);

    logic [1:0] cnt_mem [PAT_ENTRIES];
    logic [1:0] cnt_q_reg;
    pht_req_t   s2_reg;
    logic       s2_valid_reg;
    logic       wr_valid_reg;
    hist_t      wr_addr_reg;
    logic [1:0] wr_data_reg;
    logic       out_valid_reg;
    logic       pred_reg;
    hist_t      hist_out_reg;

    logic [1:0] cnt_cur;
    logic [1:0] cnt_new;
    logic       train_fire;
    logic       pred_fire;

    assign advance = !(out_valid_reg && out_stall);

    assign cnt_cur = (wr_valid_reg && (wr_addr_reg == s2_reg.hist)) ? wr_data_reg : cnt_q_reg;

    always_comb
    begin
        if (s2_reg.taken)
        begin
            cnt_new = (cnt_cur == 2'd3) ? cnt_cur : cnt_cur + 2'd1;
        end
        else
        begin
            cnt_new = (cnt_cur == 2'd0) ? cnt_cur : cnt_cur - 2'd1;
        end
    end

    assign train_fire = advance && s2_valid_reg && (s2_reg.req == REQ_TRAIN);
    assign pred_fire  = s2_valid_reg && (s2_reg.req == REQ_PREDICT);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cnt_q_reg <= cnt_mem[req.hist];
        end
        if (clr.en && (clr.addr < PAT_ENTRIES))
        begin
            cnt_mem[clr.addr[HIST_LEN-1:0]] <= 2'd0;
        end
        else if (train_fire)
        begin
            cnt_mem[s2_reg.hist] <= cnt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= req.valid;
            wr_valid_reg  <= train_fire;
            out_valid_reg <= pred_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_reg       <= req;
            wr_addr_reg  <= s2_reg.hist;
            wr_data_reg  <= cnt_new;
            pred_reg     <= cnt_cur[1];
            hist_out_reg <= s2_reg.hist;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pred_taken   = pred_reg;
    assign history_used = hist_out_reg;

endmodule

// ===== design/pag_branch_predictor.sv =====
// Top level of the two-level PAg branch predictor.
// The predictor takes one request per cycle while in_stall is low: predict, speculative
// history update or counter train. A predict result passes through the history read at
// the accepting edge, then the counter read, then the result register, in request order;
// update and train requests return nothing. When a result is held by out_stall the whole
// pipeline holds and in_stall rises. After reset both tables are cleared one entry per
// cycle, which keeps in_stall high until every entry is cleared, before the first request
// is taken.
module pag_branch_predictor
    import pag_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [63:0] branch_pc,
    input  logic        taken,
    input  logic [9:0]  history_back,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        pred_taken,
    output logic [9:0]  history_used
);

    hist_t            hist_mem [HIST_ENTRIES];
    hist_t            hist_q_reg;
    logic             s1_valid_reg;
    logic [1:0]       s1_req_reg;
    logic             s1_taken_reg;
    hist_t            s1_snap_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             hwr_valid_reg;
    logic [IDX_W-1:0] hwr_idx_reg;
    hist_t            hwr_data_reg;
    logic             clr_active_reg;
    logic [CLR_W-1:0] clr_cnt_reg;

    logic             advance;
    logic             accept;
    hist_t            hist_cur;
    hist_t            hist_new;
    logic             upd_fire;
    pht_req_t         pht_req;
    clr_t             clr;

    assign in_stall = clr_active_reg || !advance;
    assign accept   = in_valid && !in_stall;

    assign hist_cur = (hwr_valid_reg && (hwr_idx_reg == s1_idx_reg)) ? hwr_data_reg : hist_q_reg;
    assign hist_new = HIST_LEN'({hist_cur, s1_taken_reg});
    assign upd_fire = advance && s1_valid_reg && (s1_req_reg == REQ_UPDATE);

    always_comb
    begin
        pht_req.valid = s1_valid_reg
                        && ((s1_req_reg == REQ_PREDICT) || (s1_req_reg == REQ_TRAIN));
        pht_req.req   = s1_req_reg;
        pht_req.taken = s1_taken_reg;
        pht_req.hist  = (s1_req_reg == REQ_PREDICT) ? hist_cur : s1_snap_reg;
    end

    assign clr.en   = clr_active_reg;
    assign clr.addr = clr_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hist_q_reg <= hist_mem[fold_index(branch_pc)];
        end
        if (clr_active_reg && (clr_cnt_reg < HIST_ENTRIES))
        begin
            hist_mem[clr_cnt_reg[IDX_W-1:0]] <= '0;
        end
        else if (upd_fire)
        begin
            hist_mem[s1_idx_reg] <= hist_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_req_reg   <= req_type;
            s1_taken_reg <= taken;
            s1_snap_reg  <= history_back[HIST_LEN-1:0];
            s1_idx_reg   <= fold_index(branch_pc);
            hwr_idx_reg  <= s1_idx_reg;
            hwr_data_reg <= hist_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            hwr_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept;
            hwr_valid_reg <= upd_fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CLR_W'(CLR_LEN - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    pag_pht u_pht (
        .clk          (clk),
        .rst_n        (rst_n),
        .clr          (clr),
        .req          (pht_req),
        .advance      (advance),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .pred_taken   (pred_taken),
        .history_used (history_used)
    );

endmodule

// ===== design/pag_checker.sv =====
// Port-level checker for the branch predictor and its bind to the top level.
`include "pag_branch_predictor_defines.svh"

module pag_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        pred_taken,
    input logic [9:0]  history_used
);

    `PAG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pred_taken) && $stable(history_used), "Held result changed or vanished.")
    `PAG_ASSERT_IMP(a_backpressure, out_valid && out_stall, in_stall, "Request taken while a result is held.")
    `PAG_ASSERT_IMP(a_clear_after_reset, !$past(rst_n), in_stall, "Request taken before the table clear.")

endmodule

bind pag_branch_predictor pag_checker u_pag_checker (.*);

// ===== bench/pag_branch_predictor_test.sv =====
// Self-checking testbench for the PAg branch predictor, with a scoreboard and random traffic.
`timescale 1ns / 1ps

module pag_branch_predictor_test;
    import pag_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic       pred_taken;
        logic [9:0] history_used;
    } prediction_t;

    class prediction_board;
        logic [HIST_LEN-1:0] branch_history [HIST_ENTRIES];
        logic [1:0]          pattern_count  [PAT_ENTRIES];
        prediction_t         expected_preds [$];
        int                  failures;

        function new();
            foreach (branch_history[i])
            begin
                branch_history[i] = '0;
            end
            foreach (pattern_count[i])
            begin
                pattern_count[i] = '0;
            end
            failures = 0;
        endfunction

        function logic [IDX_W-1:0] branch_slot(input logic [63:0] pc);
            logic [63:0] folded;
            folded = pc >> 2;
            folded = folded ^ (folded >> 10);
            folded = folded ^ (folded >> 20);
            folded = folded ^ (folded >> 30);
            return folded[IDX_W-1:0];
        endfunction

        function logic [9:0] history_of(input logic [63:0] pc);
            return branch_history[branch_slot(pc)];
        endfunction

        function int pending();
            return expected_preds.size();
        endfunction

        function void accept_request(input logic [1:0] req, input logic [63:0] pc,
                                     input logic tk, input logic [9:0] hb);
            prediction_t     pred;
            logic [IDX_W-1:0] slot;
            logic [1:0]      count;
            slot = branch_slot(pc);
            case (req)
                REQ_PREDICT:
                begin
                    pred.history_used = branch_history[slot];
                    pred.pred_taken   = pattern_count[branch_history[slot]] >= 2'd2;
                    expected_preds.push_back(pred);
                end
                REQ_UPDATE:
                begin
                    branch_history[slot] = {branch_history[slot][HIST_LEN-2:0], tk};
                end
                REQ_TRAIN:
                begin
                    count = pattern_count[hb];
                    if (tk && count != 2'd3)
                    begin
                        count = count + 2'd1;
                    end
                    else if (!tk && count != 2'd0)
                    begin
                        count = count - 2'd1;
                    end
                    pattern_count[hb] = count;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_prediction(input logic pt, input logic [9:0] hu);
            prediction_t want;
            if (expected_preds.size() == 0)
            begin
                $error("unexpected prediction: pred_taken %0d history_used %0d", pt, hu);
                failures++;
                return;
            end
            want = expected_preds.pop_front();
            if (pt !== want.pred_taken)
            begin
                $error("pred_taken expected %0d actual %0d", want.pred_taken, pt);
                failures++;
            end
            if (hu !== want.history_used)
            begin
                $error("history_used expected %0d actual %0d", want.history_used, hu);
                failures++;
            end
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type     = REQ_PREDICT;
    logic [63:0] branch_pc    = '0;
    logic        taken        = 1'b0;
    logic [9:0]  history_back = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic        pred_taken;
    logic [9:0]  history_used;

    int idle_pct  = 0;
    int stall_pct = 0;

    prediction_board board;

    pag_branch_predictor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .branch_pc    (branch_pc),
        .taken        (taken),
        .history_back (history_back),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pred_taken   (pred_taken),
        .history_used (history_used)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            board.check_prediction(pred_taken, history_used);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_request(input logic [1:0] req, input logic [63:0] pc,
                                input logic tk, input logic [9:0] hb);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        branch_pc    <= pc;
        taken        <= tk;
        history_back <= hb;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        board.accept_request(req, pc, tk, hb);
    endtask

    task automatic wait_for_predictions();
        in_valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic run_traffic(input int count);
        int          sent;
        int          pick;
        logic [63:0] pool [12];
        int          bias [12];
        logic [63:0] pc;
        logic        dir;
        logic [9:0]  snap;
        sent = 0;
        foreach (pool[i])
        begin
            pool[i] = {$urandom, $urandom};
            bias[i] = $urandom_range(4) * 25;
        end
        while (sent < count)
        begin
            if ($urandom_range(99) < 70)
            begin
                pick = $urandom_range(11);
                pc   = pool[pick] ^ 64'($urandom_range(3));
                dir  = ($urandom_range(99) < bias[pick]);
                snap = board.history_of(pc);
                if ($urandom_range(19) == 0)
                begin
                    snap = 10'($urandom_range(1023));
                end
                send_request(REQ_PREDICT, pc, 1'($urandom_range(1)), 10'($urandom_range(1023)));
                send_request(REQ_UPDATE, pc, dir, 10'($urandom_range(1023)));
                send_request(REQ_TRAIN, pc, dir, snap);
                sent += 3;
            end
            else
            begin
                send_request(2'($urandom_range(3)), {$urandom, $urandom},
                             1'($urandom_range(1)), 10'($urandom_range(1023)));
                sent += 1;
            end
        end
    endtask

    initial
    begin
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_request(REQ_PREDICT, 64'd0, 1'b0, 10'd0);
        send_request(REQ_PREDICT, '1, 1'b1, 10'd1023);
        send_request(REQ_UNUSED, '1, 1'b1, 10'd1023);
        repeat (4) send_request(REQ_TRAIN, 64'd0, 1'b1, 10'd0);
        send_request(REQ_PREDICT, 64'd0, 1'b0, 10'd0);
        repeat (4) send_request(REQ_TRAIN, '1, 1'b0, 10'd0);
        send_request(REQ_PREDICT, 64'd0, 1'b0, 10'd0);
        send_request(REQ_UPDATE, 64'd0, 1'b1, 10'd0);
        send_request(REQ_PREDICT, 64'd0, 1'b0, 10'd0);
        repeat (2) send_request(REQ_TRAIN, 64'd0, 1'b1, 10'd1023);
        send_request(REQ_UPDATE, '1, 1'b0, 10'd1023);
        send_request(REQ_PREDICT, '1, 1'b0, 10'd0);
        repeat (2) send_request(REQ_TRAIN, 64'd0, 1'b1, 10'd1);
        send_request(REQ_PREDICT, 64'd0, 1'b1, 10'd1023);
        wait_for_predictions();

        idle_pct  = 0;
        stall_pct = 0;
        run_traffic(400);
        idle_pct  = 87;
        stall_pct = 0;
        run_traffic(400);
        wait_for_predictions();
        idle_pct  = 0;
        stall_pct = 87;
        run_traffic(400);
        idle_pct  = 15;
        stall_pct = 15;
        run_traffic(400);

        idle_pct  = 0;
        stall_pct = 0;
        wait_for_predictions();
        repeat (10) @(posedge clk);
        if (board.failures == 0)
        begin
            $display("pag_branch_predictor_test OK");
        end
        else
        begin
            $display("pag_branch_predictor_test NOT OK");
        end
        $finish;
    end

    initial
    begin
        #1600000;
        $display("pag_branch_predictor_test NOT OK");
        $finish;
    end

endmodule
